>>> rtl/cqt_pkg.sv
// ----------------------------------------------------------------------------
// cqt_pkg
// Shared types, constants and helpers for the circular queue with traverse.
// ----------------------------------------------------------------------------
package cqt_pkg;

    // Queue geometry
    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int DATA_W = 32;

    // Operation codes
    localparam logic [1:0] FN_INSERT   = 2'd0;
    localparam logic [1:0] FN_DELETE   = 2'd1;
    localparam logic [1:0] FN_TRAVERSE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } out_word_t;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Index step with wrap at the end of the store
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(DEPTH - 1))
            res = '0;
        else
            res = idx + 1'b1;
        return res;
    endfunction

endpackage

>>> rtl/circular_queue_with_traverse.sv
// ----------------------------------------------------------------------------
// circular_queue_with_traverse
// Circular queue of signed 32-bit elements with insert, delete and traverse.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_word) carries one command word:
//   func selects insert, delete or traverse, value is the element to insert.
//   Output channel (out_valid/out_ready/out_word) returns status, data and
//   last. Insert and delete give one word; traverse gives one word per
//   stored element from front to rear (last set on the rear), or a single
//   empty word. An unused func code is swallowed with no result.
//   Timing: on accept the command word is latched and the sequencer enters
//   its execute state, whose result word is then registered in the output
//   register. Each command has an accept step that issues the front-slot
//   read; traverse then gives one word per cycle unless the output stalls.
//   A new command is taken while the last result still waits in the output
//   register. When the output register is full and out_ready is low, the
//   sequencer holds its result and RAM read data and stops; nothing is lost.
//   Reset empties the queue at once; slot contents are not cleared, since
//   data read from a slot that was never written is never returned.
// ----------------------------------------------------------------------------
module circular_queue_with_traverse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cqt_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output cqt_pkg::out_word_t out_word
);

    logic               res_valid;
    logic               res_ready;
    cqt_pkg::out_word_t res_word;

    logic               out_valid_reg;
    cqt_pkg::out_word_t out_word_reg;

    cqt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // Output register takes a word when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_word_reg <= res_word;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> rtl/cqt_ram.sv
// ----------------------------------------------------------------------------
// cqt_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module cqt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/cqt_ctrl.sv
// ----------------------------------------------------------------------------
// cqt_ctrl
// Queue sequencer: holds front/rear pointers and the empty flag, latches one
// command word, reads and writes the slot store, gives result words singly.
// ----------------------------------------------------------------------------
module cqt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cqt_pkg::in_word_t in_word,
    output logic              res_valid,
    input  logic              res_ready,
    output cqt_pkg::out_word_t res_word
);

    cqt_pkg::state_t state_reg, state_next;
    cqt_pkg::in_word_t cmd_reg;

    logic [cqt_pkg::IDX_W-1:0] front_reg, front_next;
    logic [cqt_pkg::IDX_W-1:0] rear_reg, rear_next;
    logic [cqt_pkg::IDX_W-1:0] trav_reg, trav_next;
    logic                      empty_reg, empty_next;

    logic                       accept;
    logic                       fire;
    logic                       full;
    logic                       wr_en;
    logic [cqt_pkg::IDX_W-1:0]  wr_addr;
    logic                       rd_en;
    logic [cqt_pkg::IDX_W-1:0]  rd_addr;
    logic [cqt_pkg::DATA_W-1:0] rd_data;

    // Slot store
    cqt_ram #(
        .DEPTH (cqt_pkg::DEPTH),
        .WIDTH (cqt_pkg::DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd_reg.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept = in_valid && in_ready;
    assign fire   = res_valid && res_ready;
    assign full   = (cqt_pkg::wrap_inc(rear_reg) == front_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cqt_pkg::S_IDLE:
            begin
                if (accept && (in_word.func == cqt_pkg::FN_INSERT ||
                               in_word.func == cqt_pkg::FN_DELETE ||
                               in_word.func == cqt_pkg::FN_TRAVERSE))
                    state_next = cqt_pkg::S_EXEC;
            end
            cqt_pkg::S_EXEC:
            begin
                if (fire && res_word.last)
                    state_next = cqt_pkg::S_IDLE;
            end
            default: state_next = cqt_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake, memory accesses and result word
    always_comb
    begin
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        res_word.status = cqt_pkg::ST_OK;
        res_word.data   = '0;
        res_word.last   = 1'b1;
        wr_en           = 1'b0;
        wr_addr         = cqt_pkg::wrap_inc(rear_reg);
        rd_en           = 1'b0;
        rd_addr         = front_reg;
        case (state_reg)
            cqt_pkg::S_IDLE:
            begin
                // front slot is read up front for delete and traverse
                in_ready = 1'b1;
                rd_en    = accept;
            end
            cqt_pkg::S_EXEC:
            begin
                case (cmd_reg.func)
                    cqt_pkg::FN_INSERT:
                    begin
                        res_valid = 1'b1;
                        if (empty_reg)
                        begin
                            wr_addr = '0;
                            wr_en   = res_ready;
                        end
                        else if (full)
                            res_word.status = cqt_pkg::ST_FULL;
                        else
                            wr_en = res_ready;
                    end
                    cqt_pkg::FN_DELETE:
                    begin
                        res_valid = 1'b1;
                        if (empty_reg)
                            res_word.status = cqt_pkg::ST_EMPTY;
                        else
                            res_word.data = rd_data;
                    end
                    cqt_pkg::FN_TRAVERSE:
                    begin
                        res_valid = 1'b1;
                        rd_addr   = cqt_pkg::wrap_inc(trav_reg);
                        if (empty_reg)
                            res_word.status = cqt_pkg::ST_EMPTY;
                        else
                        begin
                            res_word.data = rd_data;
                            res_word.last = (trav_reg == rear_reg);
                            // fetch the next slot as this one leaves
                            rd_en = res_ready && (trav_reg != rear_reg);
                        end
                    end
                    default: res_valid = 1'b0;
                endcase
            end
            default: in_ready = 1'b0;
        endcase
    end

    // Pointer and flag updates
    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        empty_next = empty_reg;
        trav_next  = trav_reg;
        if (accept)
            trav_next = front_reg;
        if (fire && state_reg == cqt_pkg::S_EXEC)
        begin
            case (cmd_reg.func)
                cqt_pkg::FN_INSERT:
                begin
                    if (empty_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b0;
                    end
                    else if (!full)
                        rear_next = cqt_pkg::wrap_inc(rear_reg);
                end
                cqt_pkg::FN_DELETE:
                begin
                    if (!empty_reg)
                    begin
                        if (front_reg == rear_reg)
                        begin
                            front_next = '0;
                            rear_next  = '0;
                            empty_next = 1'b1;
                        end
                        else
                            front_next = cqt_pkg::wrap_inc(front_reg);
                    end
                end
                cqt_pkg::FN_TRAVERSE:
                begin
                    trav_next = cqt_pkg::wrap_inc(trav_reg);
                end
                default: trav_next = trav_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqt_pkg::S_IDLE;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            trav_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
            trav_reg  <= trav_next;
        end
    end

    // Command word
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= in_word;
    end

endmodule
